>>> design/bfa_pkg.sv
// Package for the buddy frame allocator.
// Holds field widths, default sizes, mode and status codes and frame mark bits.
// No dependencies.
package bfa_pkg;

	// Default sizes of the managed frame space.
	localparam int MAX_FRAMES_DEF = 4096;
	localparam int MAX_ORDER_DEF  = 10;

	// Fixed field widths.
	localparam int MODE_W   = 2;
	localparam int ORDER_W  = 4;
	localparam int STATUS_W = 2;
	localparam int MARK_W   = 3;

	// Request modes.
	localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ADD   = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_BLOCK = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_REQ  = 2'd3;

	// Frame marks.
	localparam logic [MARK_W-1:0] MARK_NONE      = 3'b000;
	localparam logic [MARK_W-1:0] MARK_RESERVED  = 3'b001;
	localparam logic [MARK_W-1:0] MARK_ALLOCATED = 3'b010;
	localparam logic [MARK_W-1:0] MARK_LISTED    = 3'b100;

endpackage

>>> design/buddy_frame_allocator.sv
// Buddy frame allocator top level: sequencer, frame memory, link memory, list heads.
// Depends on bfa_pkg.
//
// Channel  | Direction | Signals
// in       | input     | in_valid, in_ready, mode, order, frame_index, region_limit
// out      | output    | out_valid, out_ready, frame_number, status
// cfg      | input     | cfg_we, cfg_wdata (frame_count)
//
// After reset a clearing pass writes every frame entry before the first word is taken.
// Allocate scans the lists upward, then pops and splits until the block fits; free
// checks the block and, per merge, reads the buddy's entry and walks the list of its
// order in the link memory; add region checks every frame of the range, then writes
// each one. Every request ends with the result hand-off. One request is at work at a
// time; a finished result waits in the output register while the next word is accepted.
module buddy_frame_allocator #(
	parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF,
	parameter int MAX_ORDER  = bfa_pkg::MAX_ORDER_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [$clog2(MAX_FRAMES):0]        cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [bfa_pkg::MODE_W-1:0]         mode,
	input  logic [bfa_pkg::ORDER_W-1:0]        order,
	input  logic [$clog2(MAX_FRAMES)-1:0]      frame_index,
	input  logic [$clog2(MAX_FRAMES):0]        region_limit,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [$clog2(MAX_FRAMES)-1:0]      frame_number,
	output logic [bfa_pkg::STATUS_W-1:0]       status
);
	import bfa_pkg::*;

	localparam int FW  = $clog2(MAX_FRAMES);
	localparam int LW  = FW + 1;
	localparam int OW  = $clog2(MAX_ORDER + 2);
	localparam int HN  = MAX_ORDER + 1;
	localparam int HIW = $clog2(MAX_ORDER + 1);
	localparam int MW  = OW + MARK_W;
	localparam logic [LW-1:0] NULL_LINK = LW'(MAX_FRAMES);
	localparam logic [OW-1:0] NO_ORDER  = {OW{1'b1}};
	localparam logic [OW-1:0] TOP_ORDER = OW'(MAX_ORDER);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_A_SCAN, S_A_POP, S_A_PUSHLO,
		S_F_CHK, S_F_MRG, S_F_BCHK, S_F_WALK_RD, S_F_WALK, S_F_PUSH,
		S_D_CHK, S_D_WR, S_DONE
	} state_t;

	state_t            state_q;
	logic [FW-1:0]     clr_q;
	logic [LW-1:0]     count_q;
	logic [LW-1:0]     heads_q [HN];
	logic [OW-1:0]     cur_q;
	logic [OW-1:0]     tgt_q;
	logic [FW-1:0]     f_q;
	logic [FW-1:0]     b_q;
	logic [LW-1:0]     walk_q;
	logic [LW-1:0]     prev_q;
	logic [LW-1:0]     idx_q;
	logic [LW-1:0]     beg_q;
	logic [LW-1:0]     lim_q;
	logic [LW-1:0]     nxt_q;
	logic              fwd_q;
	logic [LW-1:0]     nl_q;
	logic [FW-1:0]     res_fn_q;
	logic [STATUS_W-1:0] res_st_q;
	logic              out_valid_q;
	logic [FW-1:0]     out_fn_q;
	logic [STATUS_W-1:0] out_st_q;

	// Frame memory holds {block order, marks}; link memory holds the list successor.
	logic [MW-1:0]     fmem [MAX_FRAMES];
	logic [LW-1:0]     lmem [MAX_FRAMES];
	logic [MW-1:0]     m_rd_q;
	logic [LW-1:0]     l_rd_q;
	logic              m_we;
	logic [FW-1:0]     m_waddr;
	logic [MW-1:0]     m_wdata;
	logic [FW-1:0]     m_raddr;
	logic              l_we;
	logic [FW-1:0]     l_waddr;
	logic [LW-1:0]     l_wdata;
	logic [FW-1:0]     l_raddr;

	logic [LW-1:0]     eff_count;
	logic              accept;
	logic [OW-1:0]     cm1;
	logic [LW-1:0]     head_cur;
	logic [LW-1:0]     head_cm1;
	logic [LW-1:0]     link_in;
	logic [LW-1:0]     hi_frame;
	logic [FW-1:0]     buddy;
	logic [LW-1:0]     idx_n;
	logic [OW-1:0]     fit_o;
	logic [OW-1:0]     rd_ord;
	logic [MARK_W-1:0] rd_marks;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign frame_number = out_fn_q;
	assign status    = out_st_q;

	// Frames managed, clamped to the memory depth.
	assign eff_count = (count_q > NULL_LINK) ? NULL_LINK : count_q;

	// Frequently used selections.
	assign cm1      = cur_q - OW'(1);
	assign head_cur = (cur_q <= TOP_ORDER) ? heads_q[cur_q[HIW-1:0]] : NULL_LINK;
	assign head_cm1 = heads_q[cm1[HIW-1:0]];
	assign link_in  = fwd_q ? nl_q : l_rd_q;
	assign hi_frame = {1'b0, f_q} + (LW'(1) << cm1);
	assign buddy    = f_q ^ (FW'(1) << cur_q);
	assign idx_n    = idx_q + LW'(1);
	assign rd_ord   = m_rd_q[MW-1:MARK_W];
	assign rd_marks = m_rd_q[MARK_W-1:0];

	// Largest aligned block that starts at the current frame and fits the region.
	always_comb begin
		logic [LW:0] sz;
		fit_o = '0;
		sz    = '0;
		for (int o = 0; o <= MAX_ORDER; o++) begin
			if (o < LW) begin
				sz = (LW + 1)'(1) << o;
				if ((({1'b0, idx_q} & (sz - (LW + 1)'(1))) == '0) &&
				    (({1'b0, idx_q} + sz) <= {1'b0, lim_q})) begin
					fit_o = OW'(o);
				end
			end
		end
	end

	// Memory addresses and write words for each step of the sequencer.
	always_comb begin
		m_we    = 1'b0;
		m_waddr = f_q;
		m_wdata = {NO_ORDER, MARK_NONE};
		m_raddr = frame_index;
		l_we    = 1'b0;
		l_waddr = f_q;
		l_wdata = head_cm1;
		l_raddr = head_cur[FW-1:0];
		case (state_q)
			S_CLEAR: begin
				m_we    = 1'b1;
				m_waddr = clr_q;
				m_wdata = {NO_ORDER, MARK_RESERVED};
			end
			S_A_POP: begin
				if (cur_q == tgt_q) begin
					m_we    = 1'b1;
					m_waddr = f_q;
					m_wdata = {tgt_q, MARK_ALLOCATED};
				end else if (hi_frame < NULL_LINK) begin
					m_we    = 1'b1;
					m_waddr = hi_frame[FW-1:0];
					m_wdata = {cm1, MARK_LISTED};
					l_we    = 1'b1;
					l_waddr = hi_frame[FW-1:0];
					l_wdata = head_cm1;
				end
			end
			S_A_PUSHLO: begin
				m_we    = 1'b1;
				m_waddr = f_q;
				m_wdata = {cm1, MARK_LISTED};
				l_we    = 1'b1;
				l_waddr = f_q;
				l_wdata = head_cm1;
			end
			S_F_MRG: begin
				m_raddr = buddy;
			end
			S_F_WALK_RD: begin
				l_raddr = walk_q[FW-1:0];
			end
			S_F_WALK: begin
				if (walk_q == {1'b0, b_q}) begin
					m_we    = 1'b1;
					m_waddr = (b_q < f_q) ? f_q : b_q;
					m_wdata = {NO_ORDER, MARK_NONE};
					if (prev_q != NULL_LINK) begin
						l_we    = 1'b1;
						l_waddr = prev_q[FW-1:0];
						l_wdata = l_rd_q;
					end
				end
			end
			S_F_PUSH: begin
				m_we    = 1'b1;
				m_waddr = f_q;
				m_wdata = {cur_q, MARK_LISTED};
				l_we    = 1'b1;
				l_waddr = f_q;
				l_wdata = head_cur;
			end
			S_D_CHK: begin
				m_raddr = idx_n[FW-1:0];
			end
			S_D_WR: begin
				m_we    = 1'b1;
				m_waddr = idx_q[FW-1:0];
				if (idx_q == nxt_q) begin
					m_wdata = {fit_o, MARK_LISTED};
					l_we    = 1'b1;
					l_waddr = idx_q[FW-1:0];
					l_wdata = heads_q[fit_o[HIW-1:0]];
				end
			end
			default: begin
			end
		endcase
	end

	// Frame and link memories, one write and one registered read each.
	always_ff @(posedge clk) begin
		if (m_we) begin
			fmem[m_waddr] <= m_wdata;
		end
		m_rd_q <= fmem[m_raddr];
		if (l_we) begin
			lmem[l_waddr] <= l_wdata;
		end
		l_rd_q <= lmem[l_raddr];
	end

	// Sequencer, list heads, configuration and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			count_q     <= NULL_LINK;
			for (int i = 0; i < HN; i++) begin
				heads_q[i] <= NULL_LINK;
			end
			cur_q       <= '0;
			tgt_q       <= '0;
			f_q         <= '0;
			b_q         <= '0;
			walk_q      <= '0;
			prev_q      <= '0;
			idx_q       <= '0;
			beg_q       <= '0;
			lim_q       <= '0;
			nxt_q       <= '0;
			fwd_q       <= 1'b0;
			nl_q        <= '0;
			res_fn_q    <= '0;
			res_st_q    <= ST_DONE;
			out_valid_q <= 1'b0;
			out_fn_q    <= '0;
			out_st_q    <= ST_DONE;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + FW'(1);
					if (clr_q == FW'(MAX_FRAMES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						res_fn_q <= '0;
						f_q      <= frame_index;
						case (mode)
							MODE_ALLOC: begin
								if ({1'b0, order} > (ORDER_W + 1)'(MAX_ORDER)) begin
									res_st_q <= ST_BAD_REQ;
									state_q  <= S_DONE;
								end else begin
									cur_q   <= OW'(order);
									tgt_q   <= OW'(order);
									state_q <= S_A_SCAN;
								end
							end
							MODE_FREE: begin
								if ({1'b0, frame_index} >= eff_count) begin
									res_st_q <= ST_BAD_FREE;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_F_CHK;
								end
							end
							MODE_ADD: begin
								if (region_limit > eff_count) begin
									res_st_q <= ST_BAD_REQ;
									state_q  <= S_DONE;
								end else if ({1'b0, frame_index} >= region_limit) begin
									res_st_q <= ST_DONE;
									state_q  <= S_DONE;
								end else begin
									idx_q   <= {1'b0, frame_index};
									beg_q   <= {1'b0, frame_index};
									lim_q   <= region_limit;
									state_q <= S_D_CHK;
								end
							end
							default: begin
								res_st_q <= ST_BAD_REQ;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				// Look for the smallest non-empty list at or above the request.
				S_A_SCAN: begin
					fwd_q <= 1'b0;
					if (cur_q > TOP_ORDER) begin
						res_st_q <= ST_NO_BLOCK;
						state_q  <= S_DONE;
					end else if (head_cur == NULL_LINK) begin
						cur_q <= cur_q + OW'(1);
					end else begin
						f_q     <= head_cur[FW-1:0];
						state_q <= S_A_POP;
					end
				end
				// Pop the head; either hand it out or push its upper half.
				S_A_POP: begin
					heads_q[cur_q[HIW-1:0]] <= link_in;
					if (cur_q == tgt_q) begin
						res_fn_q <= f_q;
						res_st_q <= ST_DONE;
						state_q  <= S_DONE;
					end else begin
						if (hi_frame < NULL_LINK) begin
							heads_q[cm1[HIW-1:0]] <= hi_frame;
						end
						state_q <= S_A_PUSHLO;
					end
				end
				// Push the lower half; its successor is forwarded to the next pop.
				S_A_PUSHLO: begin
					heads_q[cm1[HIW-1:0]] <= {1'b0, f_q};
					nl_q    <= head_cm1;
					fwd_q   <= 1'b1;
					cur_q   <= cm1;
					state_q <= S_A_POP;
				end
				// Check that the freed frame heads an allocated block.
				S_F_CHK: begin
					if (((rd_marks & (MARK_ALLOCATED | MARK_RESERVED)) != MARK_ALLOCATED) ||
					    (rd_ord > TOP_ORDER)) begin
						res_st_q <= ST_BAD_FREE;
						state_q  <= S_DONE;
					end else begin
						cur_q   <= rd_ord;
						state_q <= S_F_MRG;
					end
				end
				// Start one merge step by reading the buddy's entry.
				S_F_MRG: begin
					if ((cur_q >= TOP_ORDER) || (32'(cur_q) >= FW) ||
					    ({1'b0, buddy} >= eff_count)) begin
						state_q <= S_F_PUSH;
					end else begin
						b_q     <= buddy;
						state_q <= S_F_BCHK;
					end
				end
				S_F_BCHK: begin
					if ((rd_ord != cur_q) || (rd_marks != MARK_LISTED)) begin
						state_q <= S_F_PUSH;
					end else begin
						walk_q  <= head_cur;
						prev_q  <= NULL_LINK;
						state_q <= S_F_WALK_RD;
					end
				end
				// Walk the list of this order to find and unlink the buddy.
				S_F_WALK_RD: begin
					if (walk_q == NULL_LINK) begin
						state_q <= S_F_PUSH;
					end else begin
						state_q <= S_F_WALK;
					end
				end
				S_F_WALK: begin
					if (walk_q == {1'b0, b_q}) begin
						if (prev_q == NULL_LINK) begin
							heads_q[cur_q[HIW-1:0]] <= l_rd_q;
						end
						if (b_q < f_q) begin
							f_q <= b_q;
						end
						cur_q   <= cur_q + OW'(1);
						state_q <= S_F_MRG;
					end else begin
						prev_q  <= walk_q;
						walk_q  <= l_rd_q;
						state_q <= S_F_WALK_RD;
					end
				end
				S_F_PUSH: begin
					heads_q[cur_q[HIW-1:0]] <= {1'b0, f_q};
					res_st_q <= ST_DONE;
					state_q  <= S_DONE;
				end
				// Every frame of the region must still be reserved.
				S_D_CHK: begin
					if ((rd_marks & MARK_RESERVED) == MARK_NONE) begin
						res_st_q <= ST_BAD_REQ;
						state_q  <= S_DONE;
					end else if (idx_n >= lim_q) begin
						idx_q   <= beg_q;
						nxt_q   <= beg_q;
						state_q <= S_D_WR;
					end else begin
						idx_q <= idx_n;
					end
				end
				// Clear the marks and push aligned blocks at their first frames.
				S_D_WR: begin
					if (idx_q == nxt_q) begin
						heads_q[fit_o[HIW-1:0]] <= idx_q;
						nxt_q <= idx_q + (LW'(1) << fit_o);
					end
					idx_q <= idx_n;
					if (idx_n >= lim_q) begin
						res_st_q <= ST_DONE;
						state_q  <= S_DONE;
					end
				end
				// Hand the result to the output register once it is free.
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_fn_q    <= (res_st_q == ST_DONE) ? res_fn_q : '0;
						out_st_q    <= res_st_q;
						state_q     <= S_IDLE;
					end else begin
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> tb/tb_buddy_frame_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench for the buddy frame allocator: random and directed
// allocate, free and add-region words checked against a behavioral predictor.
// Depends on bfa_pkg and buddy_frame_allocator.

// Tracks allocator state, predicts each reply and checks the replies in order.
class alloc_tracker;
	localparam int NFR = 4096;
	localparam int MAXO = 10;
	localparam int NULL_LINK = NFR;

	typedef struct {
		logic [11:0] frame_number;
		logic [1:0]  status;
	} reply_t;

	logic [3:0] blk_ord[NFR];
	logic [2:0] marks[NFR];
	int         nxt[NFR];
	int         heads[MAXO+1];
	int         frame_count;
	int         held[$];
	reply_t     pending_replies[$];
	int         errors;

	function new();
		for (int i = 0; i < NFR; i++) begin
			blk_ord[i] = 4'hF;
			marks[i] = bfa_pkg::MARK_RESERVED;
			nxt[i] = NULL_LINK;
		end
		for (int i = 0; i <= MAXO; i++)
			heads[i] = NULL_LINK;
		frame_count = 4096;
		errors = 0;
	endfunction

	function int live_count();
		return (frame_count > NFR) ? NFR : frame_count;
	endfunction

	function void push_blk(int f, int o);
		blk_ord[f] = o[3:0];
		marks[f] = bfa_pkg::MARK_LISTED;
		nxt[f] = heads[o];
		heads[o] = f;
	endfunction

	function int pop_blk(int o);
		int f;
		f = heads[o];
		heads[o] = nxt[f];
		marks[f] &= ~bfa_pkg::MARK_LISTED;
		return f;
	endfunction

	function bit unlink_blk(int f, int o);
		int cur;
		int prev;
		cur = heads[o];
		prev = NULL_LINK;
		for (int s = 0; s < NFR && cur < NFR; s++) begin
			if (cur == f) begin
				if (prev == NULL_LINK)
					heads[o] = nxt[cur];
				else
					nxt[prev] = nxt[cur];
				marks[f] &= ~bfa_pkg::MARK_LISTED;
				return 1;
			end
			prev = cur;
			cur = nxt[cur];
		end
		return 0;
	endfunction

	// Allocate: find the smallest nonempty list, split down, hand out the lower half.
	function logic [1:0] alloc_block(int o, output int fn);
		int cur;
		int f;
		fn = 0;
		if (o > MAXO)
			return bfa_pkg::ST_BAD_REQ;
		cur = o;
		while (cur <= MAXO && heads[cur] == NULL_LINK)
			cur++;
		if (cur > MAXO)
			return bfa_pkg::ST_NO_BLOCK;
		while (cur > o) begin
			f = pop_blk(cur);
			if (f + (1 << (cur - 1)) < NFR)
				push_blk(f + (1 << (cur - 1)), cur - 1);
			push_blk(f, cur - 1);
			cur--;
		end
		f = pop_blk(o);
		marks[f] |= bfa_pkg::MARK_ALLOCATED;
		fn = f;
		return bfa_pkg::ST_DONE;
	endfunction

	// Free: release the block and merge upward while the buddy is a free head.
	function logic [1:0] free_block(int f);
		int cnt;
		int o;
		int b;
		cnt = live_count();
		if (f >= cnt)
			return bfa_pkg::ST_BAD_FREE;
		if ((marks[f] & (bfa_pkg::MARK_ALLOCATED | bfa_pkg::MARK_RESERVED))
				!= bfa_pkg::MARK_ALLOCATED)
			return bfa_pkg::ST_BAD_FREE;
		o = blk_ord[f];
		if (o > MAXO)
			return bfa_pkg::ST_BAD_FREE;
		marks[f] = bfa_pkg::MARK_NONE;
		while (o < MAXO) begin
			b = f ^ (1 << o);
			if (b >= cnt || blk_ord[b] != o || marks[b] != bfa_pkg::MARK_LISTED)
				break;
			if (!unlink_blk(b, o))
				break;
			if (b < f) begin
				blk_ord[f] = 4'hF;
				f = b;
			end else begin
				blk_ord[b] = 4'hF;
			end
			o++;
		end
		push_blk(f, o);
		return bfa_pkg::ST_DONE;
	endfunction

	// Add region: unreserve the range and seed it with the largest aligned blocks.
	function logic [1:0] add_region(int first, int lim);
		int o;
		if (lim > live_count())
			return bfa_pkg::ST_BAD_REQ;
		if (first >= lim)
			return bfa_pkg::ST_DONE;
		for (int i = first; i < lim; i++)
			if ((marks[i] & bfa_pkg::MARK_RESERVED) == 0)
				return bfa_pkg::ST_BAD_REQ;
		for (int i = first; i < lim; i++)
			marks[i] = bfa_pkg::MARK_NONE;
		while (first < lim) begin
			o = 0;
			for (int k = MAXO; k >= 0; k--) begin
				if ((first & ((1 << k) - 1)) == 0 && first + (1 << k) <= lim) begin
					o = k;
					break;
				end
			end
			push_blk(first, o);
			first += 1 << o;
		end
		return bfa_pkg::ST_DONE;
	endfunction

	// Note an accepted request word and queue the reply it must produce.
	function void take_request(logic [1:0] md, logic [3:0] ord, logic [11:0] fi,
			logic [12:0] lim);
		reply_t r;
		int fn;
		int idx[$];
		fn = 0;
		case (md)
			bfa_pkg::MODE_ALLOC: begin
				r.status = alloc_block(ord, fn);
				if (r.status == bfa_pkg::ST_DONE)
					held.push_back(fn);
			end
			bfa_pkg::MODE_FREE: begin
				r.status = free_block(fi);
				if (r.status == bfa_pkg::ST_DONE) begin
					idx = held.find_first_index(x) with (x == fi);
					if (idx.size() > 0)
						held.delete(idx[0]);
				end
			end
			bfa_pkg::MODE_ADD: r.status = add_region(fi, lim);
			default: r.status = bfa_pkg::ST_BAD_REQ;
		endcase
		r.frame_number = (r.status == bfa_pkg::ST_DONE) ? fn[11:0] : 12'd0;
		pending_replies.push_back(r);
	endfunction

	// Compare an accepted reply word against the oldest expected reply.
	function void check_reply(logic [11:0] fn, logic [1:0] st);
		reply_t r;
		if (pending_replies.size() == 0) begin
			$display("%0t unexpected reply: frame_number %0d status %0d", $time, fn, st);
			errors++;
			return;
		end
		r = pending_replies.pop_front();
		if (fn !== r.frame_number) begin
			$display("%0t frame_number expected %0d got %0d", $time, r.frame_number, fn);
			errors++;
		end
		if (st !== r.status) begin
			$display("%0t status expected %0d got %0d", $time, r.status, st);
			errors++;
		end
	endfunction
endclass

module tb_buddy_frame_allocator;
	import bfa_pkg::*;

	localparam int WATCHDOG_LIMIT = 300000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [12:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  mode;
	logic [3:0]  order;
	logic [11:0] frame_index;
	logic [12:0] region_limit;
	logic        out_valid;
	logic        out_ready;
	logic [11:0] frame_number;
	logic [1:0]  status;

	alloc_tracker tracker;
	int           out_stall;
	int           idle_cycles;
	bit           no_gaps;

	buddy_frame_allocator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.order       (order),
		.frame_index (frame_index),
		.region_limit(region_limit),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.frame_number(frame_number),
		.status      (status)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Reply side: a random stall before each word, with gap-free stretches.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall = 3;
		end else begin
			if (out_valid && out_ready) begin
				tracker.check_reply(frame_number, status);
				out_stall = no_gaps ? 0 : $urandom_range(0, 19);
			end else if (out_stall > 0) begin
				out_stall--;
			end
			out_ready <= (out_stall == 0);
		end
	end

	// Watchdog on cycles with no word moving on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Present one request word and hold it until it is accepted.
	task automatic send_word(logic [1:0] md, logic [3:0] ord, logic [11:0] fi,
			logic [12:0] lim);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		order <= ord;
		frame_index <= fi;
		region_limit <= lim;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.take_request(md, ord, fi, lim);
		if ($urandom_range(0, 49) == 0)
			no_gaps = ~no_gaps;
	endtask

	// Wait for the block to drain, then write frame_count.
	task automatic set_frame_count(logic [12:0] value);
		in_valid <= 1'b0;
		while (tracker.pending_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		tracker.frame_count = int'(value);
		cfg_we <= 1'b0;
	endtask

	// Random traffic: mostly allocate and free of held blocks, some regions and noise.
	task automatic random_traffic(int n);
		int pick;
		int first;
		logic [3:0] ord;
		logic [11:0] fi;
		logic [12:0] lim;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			ord = 4'($urandom_range(0, 15));
			fi = 12'($urandom_range(0, 4095));
			lim = 13'($urandom_range(0, 8191));
			if (pick < 42) begin
				if ($urandom_range(0, 19) < 17)
					ord = 4'($urandom_range(0, 3));
				else if ($urandom_range(0, 1))
					ord = 4'($urandom_range(4, 10));
				send_word(MODE_ALLOC, ord, fi, lim);
			end else if (pick < 82) begin
				if (tracker.held.size() > 0 && $urandom_range(0, 3) != 0)
					fi = 12'(tracker.held[$urandom_range(0, tracker.held.size() - 1)]);
				else if (tracker.held.size() > 0 && $urandom_range(0, 1))
					fi = 12'(tracker.held[0] + 1);
				send_word(MODE_FREE, ord, fi, lim);
			end else if (pick < 94) begin
				first = $urandom_range(0, 4095);
				lim = 13'(first + $urandom_range(1, 64));
				if (lim > tracker.live_count() && $urandom_range(0, 3) != 0)
					lim = 13'(tracker.live_count());
				send_word(MODE_ADD, ord, 12'(first), lim);
			end else begin
				send_word(2'($urandom_range(0, 3)), ord, fi, lim);
			end
		end
	endtask

	initial begin
		tracker = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		mode = MODE_ALLOC;
		order = '0;
		frame_index = '0;
		region_limit = '0;
		idle_cycles = 0;
		no_gaps = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Smallest frame space: a single frame.
		set_frame_count(13'd1);
		send_word(MODE_ADD, 4'd0, 12'd0, 13'd2);
		send_word(MODE_ADD, 4'd0, 12'd0, 13'd0);
		send_word(MODE_ALLOC, 4'd0, 12'd0, 13'd0);
		send_word(MODE_ADD, 4'd0, 12'd0, 13'd1);
		send_word(MODE_ADD, 4'd0, 12'd0, 13'd1);
		send_word(MODE_ALLOC, 4'd11, 12'd0, 13'd0);
		send_word(MODE_ALLOC, 4'd15, 12'd0, 13'd0);
		send_word(MODE_ALLOC, 4'd1, 12'd0, 13'd0);
		send_word(MODE_ALLOC, 4'd0, 12'd0, 13'd0);
		send_word(MODE_ALLOC, 4'd0, 12'd0, 13'd0);
		send_word(MODE_FREE, 4'd0, 12'd0, 13'd0);
		send_word(MODE_FREE, 4'd0, 12'd0, 13'd0);
		send_word(MODE_FREE, 4'd0, 12'd4095, 13'd0);
		send_word(2'd3, 4'd15, 12'd4095, 13'd8191);

		// Oversized setting acts as the full space.
		set_frame_count(13'd8191);
		send_word(MODE_ADD, 4'd0, 12'd4000, 13'd4096);
		send_word(MODE_ADD, 4'd0, 12'd1, 13'd2048);
		send_word(MODE_ADD, 4'd0, 12'd4000, 13'd8191);
		send_word(MODE_ALLOC, 4'd10, 12'd0, 13'd0);
		send_word(MODE_ALLOC, 4'd10, 12'd0, 13'd0);
		send_word(MODE_ALLOC, 4'd0, 12'd0, 13'd0);
		send_word(MODE_FREE, 4'd0, 12'd1024, 13'd0);
		send_word(MODE_FREE, 4'd0, 12'd4095, 13'd0);
		random_traffic(620);

		// Partial space: buddies beyond the limit never merge.
		set_frame_count(13'($urandom_range(100, 4095)));
		random_traffic(640);

		// Full space again.
		set_frame_count(13'd4096);
		random_traffic(640);

		in_valid <= 1'b0;
		while (tracker.pending_replies.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_replies.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
